// ===== src/dwm_pkg.sv =====
// Package for deque_with_max: operation and status codes, cell control and
// scan token types. No dependencies.
package dwm_pkg;

  localparam int unsigned DataW = 32;

  localparam logic [1:0] MODE_PUSH_FRONT = 2'd0;
  localparam logic [1:0] MODE_PUSH_REAR  = 2'd1;
  localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [1:0] MODE_POP_REAR   = 2'd3;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } ctrl_t;

  // running maximum and rear boundary value, passed cell to cell
  typedef struct packed {
    logic             go;
    logic             av;
    logic [DataW-1:0] acc;
    logic [DataW-1:0] bnd;
  } scan_t;

endpackage

// ===== src/dwm_cell.sv =====
// One storage cell of the deque chain: value, occupancy and one scan stage.
// Depends on dwm_pkg.
module dwm_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  dwm_pkg::ctrl_t           ctrl,
  input  logic [dwm_pkg::DataW-1:0] item,
  input  logic [dwm_pkg::DataW-1:0] left_val,
  input  logic                     left_occ,
  input  logic [dwm_pkg::DataW-1:0] right_val,
  input  logic                     right_occ,
  input  dwm_pkg::scan_t           scan_in,
  output logic [dwm_pkg::DataW-1:0] val,
  output logic                     occ,
  output dwm_pkg::scan_t           scan_out
);
  import dwm_pkg::*;

  logic take_max;
  logic at_bnd;

  always_ff @(posedge clk) begin
    if (ctrl.push_front) begin
      val <= left_val;
    end else if (ctrl.push_rear && !occ && left_occ) begin
      val <= item;
    end else if (ctrl.pop_front) begin
      val <= right_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.push_front) begin
      occ <= left_occ;
    end else if (ctrl.push_rear && !occ && left_occ) begin
      occ <= 1'b1;
    end else if (ctrl.pop_front) begin
      occ <= right_occ;
    end else if (ctrl.pop_rear && occ && !right_occ) begin
      occ <= 1'b0;
    end
  end

  assign take_max = occ && (!scan_in.av || ($signed(val) > $signed(scan_in.acc)));
  // first free cell still holds the item just popped from the rear
  assign at_bnd   = !occ && left_occ;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.go <= 1'b0;
    end else begin
      scan_out.go <= scan_in.go;
    end
    scan_out.av  <= scan_in.av | occ;
    scan_out.acc <= take_max ? val : scan_in.acc;
    scan_out.bnd <= at_bnd ? val : scan_in.bnd;
  end

endmodule

// ===== src/deque_with_max.sv =====
// Bounded deque of signed 32-bit items with maximum report: one item in, one
// result out per operation. Items sit in a row of DEPTH cells, front in cell 0;
// front pushes and pops shift the whole row, rear pushes and pops change only
// the boundary cell, as the item is accepted. A scan token then walks the row
// one cell a cycle to gather the maximum and the rear popped value; m_tvalid
// rises after it leaves the last cell, and the next item is taken the cycle
// after the result has been delivered. Depends on dwm_pkg and dwm_cell.
module deque_with_max #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // mode[1:0], item[33:2], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // popped_value, status, count, max_value, max_valid
);
  import dwm_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0]       state;
  logic [CntW-1:0]  count;
  logic             start;
  logic [1:0]       mode_r;
  logic [1:0]       status_r;
  logic [DataW-1:0] front_r;
  logic             accept;
  logic [1:0]       mode_in;
  logic [DataW-1:0] item_in;
  logic             is_full;
  logic             is_empty;
  logic [1:0]       status_in;
  ctrl_t            ctrl;

  logic [DataW-1:0] vals [DEPTH];
  logic             occs [DEPTH];
  scan_t            scans [DEPTH];
  scan_t            scan_head;

  logic [DataW-1:0] popped;
  logic [DataW-1:0] res_popped;
  logic [1:0]       res_status;
  logic [4:0]       res_count;
  logic [DataW-1:0] res_max;
  logic             res_valid;

  assign mode_in  = s_tdata[1:0];
  assign item_in  = s_tdata[33:2];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_full  = (count == CntW'(DEPTH));
  assign is_empty = (count == '0);

  always_comb begin
    status_in = STAT_OK;
    if (!mode_in[1] && is_full) begin
      status_in = STAT_FULL;
    end else if (mode_in[1] && is_empty) begin
      status_in = STAT_EMPTY;
    end
  end

  always_comb begin
    ctrl = '0;
    if (accept && status_in == STAT_OK) begin
      unique case (mode_in)
        MODE_PUSH_FRONT: ctrl.push_front = 1'b1;
        MODE_PUSH_REAR:  ctrl.push_rear  = 1'b1;
        MODE_POP_FRONT:  ctrl.pop_front  = 1'b1;
        MODE_POP_REAR:   ctrl.pop_rear   = 1'b1;
        default:         ctrl = '0;
      endcase
    end
  end

  assign scan_head = '{go: start, av: 1'b0, acc: '0, bnd: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DataW-1:0] lv;
    logic             lo;
    logic [DataW-1:0] rv;
    logic             ro;
    scan_t            si;

    if (i == 0) begin : g_first
      assign lv = item_in;
      assign lo = 1'b1;
      assign si = scan_head;
    end else begin : g_mid
      assign lv = vals[i-1];
      assign lo = occs[i-1];
      assign si = scans[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_inner
      assign rv = vals[i+1];
      assign ro = occs[i+1];
    end

    dwm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .item      (item_in),
      .left_val  (lv),
      .left_occ  (lo),
      .right_val (rv),
      .right_occ (ro),
      .scan_in   (si),
      .val       (vals[i]),
      .occ       (occs[i]),
      .scan_out  (scans[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      start <= 1'b0;
    end else begin
      start <= accept;
      if (ctrl.push_front || ctrl.push_rear) begin
        count <= count + 1'b1;
      end else if (ctrl.pop_front || ctrl.pop_rear) begin
        count <= count - 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) state <= S_SCAN;
        end
        S_SCAN: begin
          if (scans[DEPTH-1].go) state <= S_OUT;
        end
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= mode_in;
      status_r <= status_in;
      front_r  <= vals[0];
    end
  end

  always_comb begin
    popped = '0;
    if (status_r == STAT_OK && mode_r == MODE_POP_FRONT) begin
      popped = front_r;
    end else if (status_r == STAT_OK && mode_r == MODE_POP_REAR) begin
      popped = scans[DEPTH-1].bnd;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && scans[DEPTH-1].go) begin
      res_popped <= popped;
      res_status <= status_r;
      res_count  <= 5'(count);
      res_max    <= scans[DEPTH-1].acc;
      res_valid  <= scans[DEPTH-1].av;
    end
  end

  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {res_valid, res_max, res_count, res_status, res_popped};

endmodule
